### design/kocnt_pkg.sv
// ----------------------------------------------------------------------------
// kocnt_pkg - shared types and constants of the key count table
// Table depth, field widths, status codes and the entry types that move
// through the row of storage cells.
// ----------------------------------------------------------------------------
package kocnt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_W       = 24;
	localparam int COUNT_W     = 8;
	localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
	localparam int STATUS_W    = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
	localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(4);

	// result status codes
	localparam logic [STATUS_W-1:0] ST_MATCHED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REPORT      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REPORT_NONE = 3'd4;

	// request kinds and categories
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_REPORT = 1'b1;
	localparam logic CAT_HIGH   = 1'b0;
	localparam logic CAT_LOW    = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// one cell holds one slot of each table
	typedef struct packed {
		entry_t hi;
		entry_t lo;
	} slot_pair_t;

	// per-table shift enables
	typedef struct packed {
		logic hi;
		logic lo;
	} shift_t;

endpackage

### design/kocnt_cell.sv
// ----------------------------------------------------------------------------
// kocnt_cell - one storage cell of the rotating table row
// Holds one slot of the high table and one of the low table and loads
// the neighbor's slot when that table is rotating.
// ----------------------------------------------------------------------------
module kocnt_cell (
	input  logic                   clk,
	input  kocnt_pkg::shift_t      shift,
	input  kocnt_pkg::slot_pair_t  d,
	output kocnt_pkg::slot_pair_t  q
);

	kocnt_pkg::slot_pair_t slot_q;

	// load from the neighbor, one table at a time
	always_ff @(posedge clk) begin
		if (shift.hi) begin
			slot_q.hi <= d.hi;
		end
		if (shift.lo) begin
			slot_q.lo <= d.lo;
		end
	end

	assign q = slot_q;

endmodule

### design/keyed_occurrence_count_table_top.sv
// ----------------------------------------------------------------------------
// keyed_occurrence_count_table_top - key count tables with threshold report
// Two insertion-ordered tables of key/count pairs held in a ring of cells.
// ----------------------------------------------------------------------------
// Each request rotates the addressed table once around a ring of
// TABLE_DEPTH cells, one slot per cycle unless a report entry waits on a
// full output, and the slot at the head of the ring is compared, counted,
// appended or reported as it passes. After the walk, the final result
// word is loaded once the output register is free. A record yields a
// single word; a report yields one word per qualifying entry (or a single
// "nothing found" word), the last one flagged with m_tlast. One request is
// in flight at a time; s_tready is high only between requests, so a new
// request is taken only once the last one's final word is loaded. The
// report threshold (reset 4) is written through cfg_we / cfg_wdata; the
// user must write it only while idle, as the block does not enforce it.
module keyed_occurrence_count_table_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] key_value
	input  logic [1:0]  s_tuser,   // [0] req_type, [1] category
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [23:0] out_key, [31:24] out_count,
	                               // [38:32] distinct_keys, [39] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast    // last_result
);

	localparam int DEPTH   = kocnt_pkg::TABLE_DEPTH;
	localparam int KEY_W   = kocnt_pkg::KEY_W;
	localparam int COUNT_W = kocnt_pkg::COUNT_W;
	localparam int FILL_W  = kocnt_pkg::FILL_W;
	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q;

	// request registers
	logic               req_q;
	logic               cat_q;
	logic [KEY_W-1:0]   key_q;
	logic [FILL_W-1:0]  step_q;
	logic               hit_q;
	logic [COUNT_W-1:0] hit_count_q;
	logic [FILL_W-1:0]  fill_hi_q;
	logic [FILL_W-1:0]  fill_lo_q;
	logic [COUNT_W-1:0] threshold_q;

	// pending report entry, held until the next one shows whether it is last
	logic               pend_valid_q;
	kocnt_pkg::entry_t  pend_q;

	// output register
	logic                              out_valid_q;
	logic [kocnt_pkg::STATUS_W-1:0]    out_status_q;
	logic [KEY_W-1:0]                  out_key_q;
	logic [COUNT_W-1:0]                out_count_q;
	logic [FILL_W-1:0]                 out_distinct_q;
	logic                              out_last_q;

	// ring of cells
	kocnt_pkg::slot_pair_t cell_q [DEPTH];
	kocnt_pkg::slot_pair_t wrap;
	kocnt_pkg::shift_t     shift;

	// walk signals
	kocnt_pkg::entry_t  head;
	logic [FILL_W-1:0]  fill;
	logic               walking;
	logic               finishing;
	logic               slot_valid;
	logic               rec_hit;
	logic               rec_insert;
	logic               rep_qual;
	logic               out_free;
	logic               out_load;
	logic               stall;
	logic [COUNT_W-1:0] head_inc;
	kocnt_pkg::entry_t  head_new;

	// the cells, each fed by its successor; the tail takes the head's slot
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		kocnt_pkg::slot_pair_t d_in;
		if (i == DEPTH - 1) begin : g_tail
			assign d_in = wrap;
		end else begin : g_mid
			assign d_in = cell_q[i+1];
		end
		kocnt_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (d_in),
			.q     (cell_q[i])
		);
	end

	// head slot of the addressed table and what to do with it
	always_comb begin
		head       = (cat_q == kocnt_pkg::CAT_LOW) ? cell_q[0].lo : cell_q[0].hi;
		fill       = (cat_q == kocnt_pkg::CAT_LOW) ? fill_lo_q : fill_hi_q;
		walking    = (state_q == ST_WALK) && (step_q != DEPTH_F);
		finishing  = (state_q == ST_WALK) && (step_q == DEPTH_F);
		slot_valid = step_q < fill;
		head_inc   = (head.count == kocnt_pkg::COUNT_MAX) ?
		             head.count : head.count + COUNT_W'(1);
		rec_hit    = walking && (req_q == kocnt_pkg::REQ_RECORD) && slot_valid &&
		             (head.key == key_q);
		rec_insert = walking && (req_q == kocnt_pkg::REQ_RECORD) && !hit_q &&
		             (step_q == fill);
		rep_qual   = walking && (req_q == kocnt_pkg::REQ_REPORT) && slot_valid &&
		             (head.count >= threshold_q);
		out_free   = !out_valid_q || m_tready;
		stall      = rep_qual && pend_valid_q && !out_free;
		out_load   = (walking && !stall && rep_qual && pend_valid_q) ||
		             (finishing && out_free);
	end

	// updated head slot going around to the tail
	always_comb begin
		head_new = head;
		if (rec_hit) begin
			head_new.count = head_inc;
		end else if (rec_insert) begin
			head_new.key   = key_q;
			head_new.count = COUNT_W'(1);
		end
		wrap = cell_q[0];
		if (cat_q == kocnt_pkg::CAT_LOW) begin
			wrap.lo = head_new;
		end else begin
			wrap.hi = head_new;
		end
		shift.hi = walking && !stall && (cat_q == kocnt_pkg::CAT_HIGH);
		shift.lo = walking && !stall && (cat_q == kocnt_pkg::CAT_LOW);
	end

	// control, fill counts and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_hi_q    <= '0;
			fill_lo_q    <= '0;
			threshold_q  <= kocnt_pkg::THRESHOLD_RESET;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			step_q       <= '0;
		end else begin
			if (cfg_we) begin
				threshold_q <= cfg_wdata;
			end
			// word taken and nothing new loaded behind it
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q        <= s_tuser[0];
						cat_q        <= s_tuser[1];
						key_q        <= s_tdata[KEY_W-1:0];
						step_q       <= '0;
						hit_q        <= 1'b0;
						pend_valid_q <= 1'b0;
						state_q      <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walking && !stall) begin
						step_q <= step_q + FILL_W'(1);
						if (rec_hit) begin
							hit_q       <= 1'b1;
							hit_count_q <= head_inc;
						end
						if (rep_qual) begin
							// earlier entry is now known not to be last
							if (pend_valid_q) begin
								out_valid_q    <= 1'b1;
								out_status_q   <= kocnt_pkg::ST_REPORT;
								out_key_q      <= pend_q.key;
								out_count_q    <= pend_q.count;
								out_distinct_q <= fill;
								out_last_q     <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_q       <= head;
						end
					end else if (finishing && out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b1;
						if (req_q == kocnt_pkg::REQ_RECORD) begin
							out_key_q <= key_q;
							if (hit_q) begin
								out_status_q   <= kocnt_pkg::ST_MATCHED;
								out_count_q    <= hit_count_q;
								out_distinct_q <= fill;
							end else if (fill != DEPTH_F) begin
								out_status_q   <= kocnt_pkg::ST_INSERTED;
								out_count_q    <= COUNT_W'(1);
								out_distinct_q <= fill + FILL_W'(1);
								if (cat_q == kocnt_pkg::CAT_LOW) begin
									fill_lo_q <= fill + FILL_W'(1);
								end else begin
									fill_hi_q <= fill + FILL_W'(1);
								end
							end else begin
								out_status_q   <= kocnt_pkg::ST_FULL;
								out_count_q    <= '0;
								out_distinct_q <= fill;
							end
						end else if (pend_valid_q) begin
							out_status_q   <= kocnt_pkg::ST_REPORT;
							out_key_q      <= pend_q.key;
							out_count_q    <= pend_q.count;
							out_distinct_q <= fill;
						end else begin
							out_status_q   <= kocnt_pkg::ST_REPORT_NONE;
							out_key_q      <= '0;
							out_count_q    <= '0;
							out_distinct_q <= fill;
						end
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ports
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_distinct_q, out_count_q, out_key_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule
